// ===== hw/rtl/chacha_pkg.sv =====
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants of the ChaCha20 byte-stream cipher: the block
// state type, quarter-round step codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package chacha_pkg;

	// Number of double rounds per keystream block (4 to 10).
	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned RND_W         = $clog2(DOUBLE_ROUNDS);

	// Widths of the channel payloads.
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned POS_W      = 6;

	// The four words of "expand 32-byte k".
	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

	// Sixteen 32-bit words; word i sits at bits [32i+31:32i], so byte n of
	// the serialised keystream sits at bits [8n+7:8n].
	typedef logic [15:0][WORD_W-1:0] state_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_A    = 3'd0,
		REG_KEY_B    = 3'd1,
		REG_KEY_C    = 3'd2,
		REG_KEY_D    = 3'd3,
		REG_NONCE_LO = 3'd4,
		REG_NONCE_HI = 3'd5,
		REG_INIT_CTR = 3'd6
	} cfg_reg_t;

	// The four steps of one quarter round.
	typedef enum logic [1:0] {
		QS_AB16 = 2'd0,
		QS_CD12 = 2'd1,
		QS_AB8  = 2'd2,
		QS_CD7  = 2'd3
	} qr_step_t;

	// Block generator sequencer states.
	typedef enum logic [1:0] {
		GEN_IDLE  = 2'd0,
		GEN_ROUND = 2'd1,
		GEN_FEED  = 2'd2
	} gen_state_t;

	// Requests from the top level to the block generator.
	typedef struct packed {
		logic start;
		logic shift;
	} gen_ctrl_t;

	// Status from the block generator.
	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

endpackage

// ===== hw/rtl/chacha_if.sv =====
// ----------------------------------------------------------------------------
// chacha_if
// Valid/ready channels of the cipher: input bytes, result bytes and
// configuration writes.
// ----------------------------------------------------------------------------
interface chacha_item_if;
	import chacha_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_in;
	logic              last_byte;

	modport source (output valid, output data_in, output last_byte, input ready);
	modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

interface chacha_result_if;
	import chacha_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_out;
	logic              end_of_message;

	modport source (output valid, output data_out, output end_of_message, input ready);
	modport sink   (input valid, input data_out, input end_of_message, output ready);
endinterface

interface chacha_cfg_if;
	import chacha_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/chacha_lane.sv =====
// ----------------------------------------------------------------------------
// chacha_lane
// One lane of the shared quarter-round unit: a single add, XOR and rotate
// step (x += y; z = (z ^ x) <<< r), with r chosen by the step code.
// ----------------------------------------------------------------------------
module chacha_lane (
	input  chacha_pkg::qr_step_t          step,
	input  logic [chacha_pkg::WORD_W-1:0] x,
	input  logic [chacha_pkg::WORD_W-1:0] y,
	input  logic [chacha_pkg::WORD_W-1:0] z,
	output logic [chacha_pkg::WORD_W-1:0] x_new,
	output logic [chacha_pkg::WORD_W-1:0] z_new
);
	import chacha_pkg::*;

	logic [WORD_W-1:0] mix;

	// Add, then XOR the sum into the third word.
	assign x_new = x + y;
	assign mix   = z ^ x_new;

	// Rotate left by the amount of this step.
	always_comb begin
		case (step)
			QS_AB16: z_new = {mix[15:0], mix[31:16]};
			QS_CD12: z_new = {mix[19:0], mix[31:20]};
			QS_AB8:  z_new = {mix[23:0], mix[31:24]};
			QS_CD7:  z_new = {mix[24:0], mix[31:25]};
			default: z_new = mix;
		endcase
	end

endmodule

// ===== hw/rtl/chacha_block_gen.sv =====
// ----------------------------------------------------------------------------
// chacha_block_gen
// Keystream block generator. Four lanes work one quarter-round step per cycle
// on the columns or diagonals of the state; a small sequencer runs the double
// rounds and the feed-forward. The finished block then serves as a byte shift
// register from which the top level takes one keystream byte per beat.
// ----------------------------------------------------------------------------
module chacha_block_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chacha_pkg::gen_ctrl_t         ctrl,
	input  chacha_pkg::state_t            init,
	output chacha_pkg::gen_stat_t         stat,
	output logic [chacha_pkg::BYTE_W-1:0] ks_byte
);
	import chacha_pkg::*;

	gen_state_t        state_q, state_d;
	logic [1:0]        step_q;
	logic              diag_q;
	logic [RND_W-1:0]  round_q;
	state_t            w_q, w_d;
	logic [511:0]      w_flat;
	logic              step_odd;
	logic              last_step;

	logic [WORD_W-1:0] lane_x   [4];
	logic [WORD_W-1:0] lane_y   [4];
	logic [WORD_W-1:0] lane_z   [4];
	logic [WORD_W-1:0] lane_xn  [4];
	logic [WORD_W-1:0] lane_zn  [4];
	logic [WORD_W-1:0] w_rnd    [16];

	assign step_odd  = step_q[0];
	assign last_step = (step_q == 2'd3) && diag_q && (round_q == RND_W'(DOUBLE_ROUNDS - 1));
	assign w_flat    = w_q;
	assign ks_byte   = w_q[0][BYTE_W-1:0];

	// Lanes: pick a, b, c, d of a column or a diagonal and apply one step.
	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam int unsigned BD = 4 + ((l + 1) % 4);
		localparam int unsigned CD = 8 + ((l + 2) % 4);
		localparam int unsigned DD = 12 + ((l + 3) % 4);

		logic [WORD_W-1:0] a, b, c, d;

		assign a = w_q[l];
		assign b = diag_q ? w_q[BD] : w_q[4 + l];
		assign c = diag_q ? w_q[CD] : w_q[8 + l];
		assign d = diag_q ? w_q[DD] : w_q[12 + l];

		assign lane_x[l] = step_odd ? c : a;
		assign lane_y[l] = step_odd ? d : b;
		assign lane_z[l] = step_odd ? b : d;

		chacha_lane u_lane (
			.step  (qr_step_t'(step_q)),
			.x     (lane_x[l]),
			.y     (lane_y[l]),
			.z     (lane_z[l]),
			.x_new (lane_xn[l]),
			.z_new (lane_zn[l])
		);
	end

	// Write-back: each word takes the result of the lane that owns it.
	for (genvar j = 0; j < 4; j++) begin : g_wb
		localparam int unsigned L1 = (j + 3) % 4;
		localparam int unsigned L2 = (j + 2) % 4;
		localparam int unsigned L3 = (j + 1) % 4;

		assign w_rnd[j]      = step_odd ? w_q[j] : lane_xn[j];
		assign w_rnd[4 + j]  = !step_odd ? w_q[4 + j] :
		                       (diag_q ? lane_zn[L1] : lane_zn[j]);
		assign w_rnd[8 + j]  = !step_odd ? w_q[8 + j] :
		                       (diag_q ? lane_xn[L2] : lane_xn[j]);
		assign w_rnd[12 + j] = step_odd ? w_q[12 + j] :
		                       (diag_q ? lane_zn[L3] : lane_zn[j]);
	end

	// Sequencer next state and status.
	always_comb begin
		state_d   = state_q;
		stat.busy = 1'b1;
		stat.done = 1'b0;
		case (state_q)
			GEN_IDLE: begin
				stat.busy = 1'b0;
				if (ctrl.start) begin
					state_d = GEN_ROUND;
				end
			end
			GEN_ROUND: begin
				if (last_step) begin
					state_d = GEN_FEED;
				end
			end
			GEN_FEED: begin
				stat.done = 1'b1;
				state_d   = GEN_IDLE;
			end
			default: begin
				state_d = GEN_IDLE;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step, diagonal and double-round counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			diag_q  <= 1'b0;
			round_q <= '0;
		end else if (state_q == GEN_IDLE) begin
			step_q  <= '0;
			diag_q  <= 1'b0;
			round_q <= '0;
		end else if (state_q == GEN_ROUND) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				diag_q <= !diag_q;
				if (diag_q) begin
					round_q <= round_q + RND_W'(1);
				end
			end
		end
	end

	// Next value of the working state: load, round step, feed-forward or shift.
	always_comb begin
		w_d = w_q;
		case (state_q)
			GEN_IDLE: begin
				if (ctrl.start) begin
					w_d = init;
				end else if (ctrl.shift) begin
					w_d = {8'h00, w_flat[511:8]};
				end
			end
			GEN_ROUND: begin
				for (int k = 0; k < 16; k++) begin
					w_d[k] = w_rnd[k];
				end
			end
			GEN_FEED: begin
				for (int k = 0; k < 16; k++) begin
					w_d[k] = w_q[k] + init[k];
				end
			end
			default: begin
				w_d = w_q;
			end
		endcase
	end

	// Working state and keystream block.
	always_ff @(posedge clk) begin
		w_q <= w_d;
	end

endmodule

// ===== hw/rtl/chacha20_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 byte-stream cipher: each input byte is XORed with the next byte of
// keystream; result beats come from an output register and appear in the
// cycle after the input beat is accepted.
// A keystream block is made by load, the double rounds in the four-lane
// quarter-round unit and feed-forward, during which no byte is taken.
// The 64 bytes of a block then go at up to one beat per cycle while the result
// side is ready; no next block is made while one is held.
// Reset clears the configuration, position, counter and handshake registers
// to zero and starts with no keystream block held; data registers are not reset.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top (
	input  logic clk,
	input  logic arst_n,
	chacha_item_if.sink     item,
	chacha_result_if.source result,
	chacha_cfg_if.sink      cfg
);
	import chacha_pkg::*;

	logic [CFG_DATA_W-1:0] key_a_q, key_b_q, key_c_q, key_d_q, nonce_lo_q;
	logic [WORD_W-1:0]     nonce_hi_q, init_ctr_q;
	logic [WORD_W-1:0]     ctr_q;
	logic [POS_W-1:0]      pos_q;
	logic                  ks_ready_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_data_q;
	logic                  out_eom_q;

	logic                  cfg_fire;
	logic                  cfg_restart;
	logic                  item_fire;
	logic [BYTE_W-1:0]     ks_byte;
	state_t                init;
	gen_ctrl_t             gen_ctrl;
	gen_stat_t             gen_stat;

	// Handshakes. Configuration goes first; bytes wait while the block is made.
	assign cfg.ready  = !gen_stat.busy;
	assign cfg_fire   = cfg.valid && cfg.ready;
	assign item.ready = ks_ready_q && !cfg.valid && (!out_valid_q || result.ready);
	assign item_fire  = item.valid && item.ready;

	assign result.valid          = out_valid_q;
	assign result.data_out       = out_data_q;
	assign result.end_of_message = out_eom_q;

	// Initial block state from the constants, key, counter and nonce.
	always_comb begin
		init[0]  = SIGMA_0;
		init[1]  = SIGMA_1;
		init[2]  = SIGMA_2;
		init[3]  = SIGMA_3;
		init[4]  = key_a_q[31:0];
		init[5]  = key_a_q[63:32];
		init[6]  = key_b_q[31:0];
		init[7]  = key_b_q[63:32];
		init[8]  = key_c_q[31:0];
		init[9]  = key_c_q[63:32];
		init[10] = key_d_q[31:0];
		init[11] = key_d_q[63:32];
		init[12] = ctr_q;
		init[13] = nonce_lo_q[31:0];
		init[14] = nonce_lo_q[63:32];
		init[15] = nonce_hi_q;
	end

	// A new block is started when a byte waits and no keystream is held.
	assign gen_ctrl.start = item.valid && !ks_ready_q && !gen_stat.busy && !cfg_fire;
	assign gen_ctrl.shift = item_fire;

	// A write to a known register restarts the message.
	assign cfg_restart = cfg_fire && (cfg.index inside {REG_KEY_A, REG_KEY_B, REG_KEY_C,
		REG_KEY_D, REG_NONCE_LO, REG_NONCE_HI, REG_INIT_CTR});

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q    <= '0;
			key_b_q    <= '0;
			key_c_q    <= '0;
			key_d_q    <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_KEY_A:    key_a_q    <= cfg.data;
				REG_KEY_B:    key_b_q    <= cfg.data;
				REG_KEY_C:    key_c_q    <= cfg.data;
				REG_KEY_D:    key_d_q    <= cfg.data;
				REG_NONCE_LO: nonce_lo_q <= cfg.data;
				REG_NONCE_HI: nonce_hi_q <= cfg.data[WORD_W-1:0];
				REG_INIT_CTR: init_ctr_q <= cfg.data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Message position, block counter and keystream-held flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ctr_q      <= '0;
			ks_ready_q <= 1'b0;
		end else if (cfg_restart) begin
			pos_q      <= '0;
			ctr_q      <= (cfg.index == REG_INIT_CTR) ? cfg.data[WORD_W-1:0] : init_ctr_q;
			ks_ready_q <= 1'b0;
		end else if (item_fire) begin
			if (item.last_byte) begin
				pos_q      <= '0;
				ctr_q      <= init_ctr_q;
				ks_ready_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == {POS_W{1'b1}}) begin
					ctr_q      <= ctr_q + WORD_W'(1);
					ks_ready_q <= 1'b0;
				end
			end
		end else if (gen_stat.done) begin
			ks_ready_q <= 1'b1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			out_data_q <= item.data_in ^ ks_byte;
			out_eom_q  <= item.last_byte;
		end
	end

	chacha_block_gen u_block_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (gen_ctrl),
		.init    (init),
		.stat    (gen_stat),
		.ks_byte (ks_byte)
	);

endmodule

// ===== tb/chacha20_stream_cipher_top_tb.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top_tb
// Self-checking bench for the ChaCha20 byte-stream cipher. Bytes are pushed
// through the item channel with random gaps, and results are taken with random
// back-pressure. Each accepted byte is run through a local ChaCha20 block
// function and position tracker. The first bytes after reset are also checked
// against the published all-zero-key keystream. Register writes between
// phases sweep keys, nonces and the initial counter, including counter wrap,
// aborted messages and writes to the unused register index.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chacha_pkg::*;

	localparam int unsigned          CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned          RANDOM_ITEMS = 1700;
	localparam int unsigned          DRAIN_CYCLES = 200;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

	// One result beat: the ciphered byte and the copied end flag.
	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              end_of_message;
	} cipher_beat_t;

	// One row of the directed table; known marks a typed-in expected byte.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              known;
		logic [BYTE_W-1:0] known_out;
	} stim_row_t;

	// After reset the key, nonce and counter are all zero, so plain zero bytes
	// return the well-known zero-key keystream; all-ones bytes return its inverse.
	localparam int unsigned DIRECTED_ROWS = 20;
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, 8'h76},
		'{8'h00, 1'b0, 1'b1, 8'hb8},
		'{8'h00, 1'b0, 1'b1, 8'he0},
		'{8'h00, 1'b0, 1'b1, 8'had},
		'{8'h00, 1'b0, 1'b1, 8'ha0},
		'{8'h00, 1'b0, 1'b1, 8'hf1},
		'{8'h00, 1'b0, 1'b1, 8'h3d},
		'{8'h00, 1'b1, 1'b1, 8'h90},
		'{8'hff, 1'b0, 1'b1, 8'h89},
		'{8'hff, 1'b0, 1'b1, 8'h47},
		'{8'hff, 1'b1, 1'b1, 8'h1f},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'h7f, 1'b0, 1'b0, 8'h00},
		'{8'h01, 1'b0, 1'b0, 8'h00},
		'{8'hfe, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'haa, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b1, 1'b0, 8'h00},
		'{8'h3c, 1'b1, 1'b0, 8'h00},
		'{8'hc3, 1'b0, 1'b0, 8'h00}
	};

	logic clk;
	logic arst_n;

	chacha_item_if   item_ch ();
	chacha_result_if result_ch ();
	chacha_cfg_if    cfg_ch ();

	chacha20_stream_cipher_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the cipher settings and keystream position.
	logic [63:0]     key_a, key_b, key_c, key_d, nonce_lo;
	logic [31:0]     nonce_hi, ctr_init;
	logic [511:0]    ks_bits;
	logic [POS_W-1:0] ks_pos;
	logic [31:0]     ks_ctr;
	logic            ks_valid;

	cipher_beat_t expected_beats [$];
	int unsigned  mismatches = 0;
	int           msg_left = 0;
	bit           items_quiet = 1'b0;
	bit           results_quiet = 1'b0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [127:0] quarter_round(input logic [31:0] a, b, c, d);
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return {a, b, c, d};
	endfunction

	// Full keystream block for the given counter, byte n at bits [8n+7:8n].
	function automatic logic [511:0] keystream_block(input logic [31:0] ctr);
		state_t init;
		state_t w;
		init[0]  = SIGMA_0;          init[1]  = SIGMA_1;
		init[2]  = SIGMA_2;          init[3]  = SIGMA_3;
		init[4]  = key_a[31:0];      init[5]  = key_a[63:32];
		init[6]  = key_b[31:0];      init[7]  = key_b[63:32];
		init[8]  = key_c[31:0];      init[9]  = key_c[63:32];
		init[10] = key_d[31:0];      init[11] = key_d[63:32];
		init[12] = ctr;
		init[13] = nonce_lo[31:0];   init[14] = nonce_lo[63:32];
		init[15] = nonce_hi;
		w = init;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			{w[0], w[4], w[8],  w[12]} = quarter_round(w[0], w[4], w[8],  w[12]);
			{w[1], w[5], w[9],  w[13]} = quarter_round(w[1], w[5], w[9],  w[13]);
			{w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
			{w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
			{w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
			{w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
			{w[2], w[7], w[8],  w[13]} = quarter_round(w[2], w[7], w[8],  w[13]);
			{w[3], w[4], w[9],  w[14]} = quarter_round(w[3], w[4], w[9],  w[14]);
		end
		for (int i = 0; i < 16; i++) begin
			w[i] = w[i] + init[i];
		end
		return w;
	endfunction

	function automatic void restart_keystream();
		ks_pos   = '0;
		ks_valid = 1'b0;
		ks_ctr   = ctr_init;
	endfunction

	// Register write as the block sees it; unknown indexes leave all untouched.
	function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [63:0] v);
		case (idx)
			REG_KEY_A:    key_a = v;
			REG_KEY_B:    key_b = v;
			REG_KEY_C:    key_c = v;
			REG_KEY_D:    key_d = v;
			REG_NONCE_LO: nonce_lo = v;
			REG_NONCE_HI: nonce_hi = v[31:0];
			REG_INIT_CTR: ctr_init = v[31:0];
			default:      return;
		endcase
		restart_keystream();
	endfunction

	// Ciphers one byte and advances the position, block counter and message.
	function automatic cipher_beat_t cipher_byte(input logic [BYTE_W-1:0] d,
			input logic l);
		cipher_beat_t beat;
		if (!ks_valid) begin
			ks_bits  = keystream_block(ks_ctr);
			ks_valid = 1'b1;
		end
		beat.data_out       = d ^ ks_bits[ks_pos * 8 +: 8];
		beat.end_of_message = l;
		ks_pos = ks_pos + 1'b1;
		if (ks_pos == '0) begin
			ks_valid = 1'b0;
			ks_ctr   = ks_ctr + 1'b1;
		end
		if (l) begin
			restart_keystream();
		end
		return beat;
	endfunction

	// Random register value, biased towards the extremes.
	function automatic logic [63:0] reg_value(input logic [CFG_IDX_W-1:0] idx);
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0:       v = '0;
			1:       v = '1;
			default: v = {$urandom, $urandom};
		endcase
		if (idx == REG_INIT_CTR && $urandom_range(0, 2) == 0) begin
			v[31:0] = 32'hffff_ffff - $urandom_range(0, 1);
		end
		return v;
	endfunction

	function automatic int draw_msg_len();
		case ($urandom_range(0, 9))
			6, 7, 8: return $urandom_range(17, 100);
			9:       return $urandom_range(101, 200);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	// Sends one byte beat; valid is only lowered when a gap comes before it.
	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic l,
			input bit use_typed, input logic [BYTE_W-1:0] typed_out);
		int           gap;
		cipher_beat_t beat;
		gap = items_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.data_in   <= d;
		item_ch.last_byte <= l;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		beat = cipher_byte(d, l);
		if (use_typed) begin
			beat.data_out = typed_out;
		end
		expected_beats.push_back(beat);
	endtask

	// Writes one register; a real register also ends the message in progress.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		int gap;
		gap = items_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		store_register(idx, v);
		if (idx != REG_UNUSED) begin
			msg_left = 0;
		end
	endtask

	task automatic wait_drained();
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	// Result side: random back-pressure and comparison with the oldest beat.
	initial begin : result_side
		int           stall;
		cipher_beat_t want;
		cipher_beat_t got;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = results_quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.data_out       = result_ch.data_out;
			got.end_of_message = result_ch.end_of_message;
			if (expected_beats.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, actual %02h/%0b",
					$time, got.data_out, got.end_of_message);
			end else begin
				want = expected_beats.pop_front();
				if (got.data_out !== want.data_out) begin
					mismatches++;
					$display("%0t: data_out expected %02h, actual %02h",
						$time, want.data_out, got.data_out);
				end
				if (got.end_of_message !== want.end_of_message) begin
					mismatches++;
					$display("%0t: end_of_message expected %0b, actual %0b",
						$time, want.end_of_message, got.end_of_message);
				end
			end
		end
	end

	// Cycle limit.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("chacha20_stream_cipher_top_tb: errors");
		$finish;
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin : stimulus
		int          sent;
		int          phase_len;
		int          n;
		bit          first;
		logic [CFG_IDX_W-1:0] idx;

		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.data_in   <= '0;
		item_ch.last_byte <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= '0;
		cfg_ch.data       <= '0;
		key_a = '0; key_b = '0; key_c = '0; key_d = '0;
		nonce_lo = '0; nonce_hi = '0; ctr_init = '0;
		ks_bits = '0;
		restart_keystream();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; the typed bytes only hold for the full round count.
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].known && DOUBLE_ROUNDS == 10,
				directed_rows[i].known_out);
		end
		item_ch.valid <= 1'b0;
		wait_drained();

		// Random phases. The first writes every register and runs one long
		// message from the top counter value, so it crosses the counter wrap.
		sent  = 0;
		first = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			items_quiet   = ($urandom_range(0, 3) == 0);
			results_quiet = ($urandom_range(0, 3) == 0);
			if (first) begin
				for (int r = REG_KEY_A; r < REG_INIT_CTR; r++) begin
					idx = CFG_IDX_W'(r);
					write_reg(idx, reg_value(idx));
				end
				write_reg(REG_INIT_CTR, {$urandom, 32'hffff_ffff});
				write_reg(REG_UNUSED, {$urandom, $urandom});
				msg_left  = 150;
				phase_len = 160;
			end else begin
				case ($urandom_range(0, 5))
					0: ;
					1: write_reg(REG_UNUSED, {$urandom, $urandom});
					default: begin
						n = $urandom_range(1, 4);
						repeat (n) begin
							idx = CFG_IDX_W'($urandom_range(REG_KEY_A, REG_UNUSED));
							write_reg(idx, reg_value(idx));
						end
					end
				endcase
				phase_len = $urandom_range(20, 150);
			end
			cfg_ch.valid <= 1'b0;
			first = 1'b0;
			repeat (phase_len) begin
				if (msg_left == 0) begin
					msg_left = draw_msg_len();
				end
				send_byte(BYTE_W'($urandom_range(0, 255)), msg_left == 1, 1'b0, '0);
				msg_left--;
				sent++;
			end
			item_ch.valid <= 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("chacha20_stream_cipher_top_tb: clean");
		end else begin
			$display("chacha20_stream_cipher_top_tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_if.sv
hw/rtl/chacha_lane.sv
hw/rtl/chacha_block_gen.sv
hw/rtl/chacha20_stream_cipher_top.sv
tb/chacha20_stream_cipher_top_tb.sv
